// ===== rtl/i2a_pkg.sv =====
// shared types, constants and tables for the padded integer to ascii converter
package i2a_pkg;

  localparam int VALUE_W = 32;
  localparam int RADIX_W = 5;
  localparam int WIDTH_W = 6;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int DIGIT_W = 4;

  localparam int MAX_DIGITS  = 32;
  localparam int MAX_WIDTH   = 63;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

  // divider retires this many quotient bits per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] RADIX_SIGNED = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // classified request as handed from the front to the back
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic [RADIX_W-1:0] base;
    logic [WIDTH_W-1:0] width;
    logic [CHAR_W-1:0]  pad;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic               neg;
    logic               zero;
  } desc_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic [RADIX_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_PAD,
    ST_DIGIT
  } back_state_t;

endpackage

// ===== rtl/i2a_front.sv =====
// front end: accepts requests and classifies sign, radix, width and zero
module i2a_front (
  input  logic                         push,
  input  logic [i2a_pkg::VALUE_W-1:0]  value,
  input  logic [i2a_pkg::RADIX_W-1:0]  radix,
  input  logic [i2a_pkg::WIDTH_W-1:0]  min_width,
  input  logic [i2a_pkg::CHAR_W-1:0]   pad_char,
  input  logic [i2a_pkg::COLOR_W-1:0]  fg_color,
  input  logic [i2a_pkg::COLOR_W-1:0]  bg_color,
  input  logic                         q_full,
  output logic                         full,
  output logic                         wr_en,
  output i2a_pkg::desc_t               wr_data
);

  logic [i2a_pkg::RADIX_W-1:0] base;
  logic                        neg;

  always_comb begin
    if (radix < i2a_pkg::RADIX_MIN) begin
      base = i2a_pkg::RADIX_MIN;
    end else if (radix > i2a_pkg::RADIX_MAX) begin
      base = i2a_pkg::RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  assign neg = (base == i2a_pkg::RADIX_SIGNED) && value[i2a_pkg::VALUE_W-1];

  always_comb begin
    wr_data.base = base;
    wr_data.neg  = neg;
    wr_data.zero = (value == '0);
    wr_data.mag  = neg ? (~value + i2a_pkg::VALUE_W'(1)) : value;
    if (min_width > i2a_pkg::WIDTH_W'(i2a_pkg::MAX_WIDTH)) begin
      wr_data.width = i2a_pkg::WIDTH_W'(i2a_pkg::MAX_WIDTH);
    end else begin
      wr_data.width = min_width;
    end
    wr_data.pad = pad_char;
    wr_data.fg  = fg_color;
    wr_data.bg  = bg_color;
  end

  assign full  = q_full;
  assign wr_en = push && !q_full;

endmodule

// ===== rtl/i2a_queue.sv =====
// short request queue between front and back
module i2a_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  i2a_pkg::desc_t wr_data,
  input  logic           rd_en,
  output i2a_pkg::desc_t rd_data,
  output logic           full,
  output logic           empty
);

  i2a_pkg::desc_t                entries [i2a_pkg::Q_DEPTH];
  logic [i2a_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [i2a_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [i2a_pkg::Q_CNT_W-1:0]   count;

  function automatic logic [i2a_pkg::Q_PTR_W-1:0] ptr_inc(
    input logic [i2a_pkg::Q_PTR_W-1:0] p
  );
    if (p == i2a_pkg::Q_PTR_W'(i2a_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + i2a_pkg::Q_PTR_W'(1);
  endfunction

  assign full    = (count == i2a_pkg::Q_CNT_W'(i2a_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + i2a_pkg::Q_CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - i2a_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/i2a_divider.sv =====
// iterative restoring divider by a small radix, several quotient bits per cycle
module i2a_divider (
  input  logic              clk,
  input  logic              rst,
  input  i2a_pkg::div_req_t req,
  output i2a_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic [i2a_pkg::DIV_CNT_W-1:0] cnt;
  logic [i2a_pkg::VALUE_W-1:0]   quo;
  logic [i2a_pkg::RADIX_W-1:0]   rem;
  logic [i2a_pkg::RADIX_W-1:0]   base;
  logic [i2a_pkg::VALUE_W-1:0]   quo_next;
  logic [i2a_pkg::RADIX_W-1:0]   rem_next;
  logic                          done;

  // rem stays below base, so it fits one bit less than the radix field
  always_comb begin
    logic [i2a_pkg::RADIX_W-1:0] r;
    logic [i2a_pkg::VALUE_W-1:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < i2a_pkg::DIV_BITS; i++) begin
      r = {r[i2a_pkg::RADIX_W-2:0], q[i2a_pkg::VALUE_W-1]};
      q = {q[i2a_pkg::VALUE_W-2:0], 1'b0};
      if (r >= base) begin
        r    = r - base;
        q[0] = 1'b1;
      end
    end
    quo_next = q;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= req.dividend;
      rem  <= '0;
      base <= req.divisor;
      cnt  <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
      cnt <= cnt + i2a_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == i2a_pkg::DIV_CNT_W'(i2a_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

// ===== rtl/i2a_back.sv =====
// back end: digit extraction sequencer, digit store and result register
module i2a_back (
  input  logic                         clk,
  input  logic                         rst,
  input  i2a_pkg::desc_t               q_data,
  input  logic                         q_empty,
  output logic                         q_pop,
  output i2a_pkg::div_req_t            div_req,
  input  i2a_pkg::div_rsp_t            div_rsp,
  input  logic                         pop,
  output logic                         empty,
  output logic [i2a_pkg::CHAR_W-1:0]   char_out,
  output logic [i2a_pkg::COLOR_W-1:0]  fg_out,
  output logic [i2a_pkg::COLOR_W-1:0]  bg_out,
  output logic                         last_char
);

  i2a_pkg::back_state_t state;
  i2a_pkg::back_state_t state_next;

  logic [i2a_pkg::DIGIT_W-1:0]     digits [i2a_pkg::MAX_DIGITS];
  logic [i2a_pkg::DIGIT_CNT_W-1:0] ndig;
  logic [i2a_pkg::DIGIT_IDX_W-1:0] idx;
  logic [i2a_pkg::WIDTH_W-1:0]     pad_left;
  logic [i2a_pkg::WIDTH_W-1:0]     width;
  logic [i2a_pkg::RADIX_W-1:0]     base;
  logic [i2a_pkg::CHAR_W-1:0]      pad;
  logic [i2a_pkg::COLOR_W-1:0]     fg;
  logic [i2a_pkg::COLOR_W-1:0]     bg;
  logic                            neg;

  logic                            out_valid;
  logic                            room;
  logic                            emit;
  logic                            emit_last;
  logic [i2a_pkg::CHAR_W-1:0]      emit_char;

  logic [i2a_pkg::DIGIT_CNT_W-1:0] ndig_inc;
  logic                            div_finish;
  logic                            pad_needed;

  assign room       = !out_valid || pop;
  assign ndig_inc   = ndig + i2a_pkg::DIGIT_CNT_W'(1);
  assign div_finish = div_rsp.done &&
                      ((div_rsp.quot == '0) ||
                       (ndig_inc == i2a_pkg::DIGIT_CNT_W'(i2a_pkg::MAX_DIGITS)));
  assign pad_needed = (width > i2a_pkg::WIDTH_W'(ndig_inc));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      i2a_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_next = q_data.zero ? i2a_pkg::ST_DIGIT : i2a_pkg::ST_DIV;
        end
      end
      i2a_pkg::ST_DIV: begin
        if (div_finish) begin
          if (neg) begin
            state_next = i2a_pkg::ST_SIGN;
          end else if (pad_needed) begin
            state_next = i2a_pkg::ST_PAD;
          end else begin
            state_next = i2a_pkg::ST_DIGIT;
          end
        end
      end
      i2a_pkg::ST_SIGN: begin
        if (room) begin
          state_next = (pad_left != '0) ? i2a_pkg::ST_PAD : i2a_pkg::ST_DIGIT;
        end
      end
      i2a_pkg::ST_PAD: begin
        if (room && pad_left == i2a_pkg::WIDTH_W'(1)) begin
          state_next = i2a_pkg::ST_DIGIT;
        end
      end
      i2a_pkg::ST_DIGIT: begin
        if (room && idx == '0) begin
          state_next = i2a_pkg::ST_IDLE;
        end
      end
      default: state_next = i2a_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quot;
    div_req.divisor  = base;
    emit             = 1'b0;
    emit_last        = 1'b0;
    emit_char        = pad;
    case (state)
      i2a_pkg::ST_IDLE: begin
        q_pop            = !q_empty;
        div_req.start    = !q_empty && !q_data.zero;
        div_req.dividend = q_data.mag;
        div_req.divisor  = q_data.base;
      end
      i2a_pkg::ST_DIV: begin
        div_req.start = div_rsp.done && !div_finish;
      end
      i2a_pkg::ST_SIGN: begin
        emit      = room;
        emit_char = i2a_pkg::CHAR_MINUS;
      end
      i2a_pkg::ST_PAD: begin
        emit      = room;
        emit_char = pad;
      end
      i2a_pkg::ST_DIGIT: begin
        emit      = room;
        emit_last = (idx == '0);
        emit_char = i2a_pkg::DIGIT_CHARS[digits[idx]];
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2a_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request fields and digit bookkeeping
  always_ff @(posedge clk) begin
    if (state == i2a_pkg::ST_IDLE && !q_empty) begin
      width <= q_data.width;
      base  <= q_data.base;
      pad   <= q_data.pad;
      fg    <= q_data.fg;
      bg    <= q_data.bg;
      ndig  <= '0;
      // zero goes straight out as a single digit with no sign or padding
      neg       <= q_data.neg && !q_data.zero;
      idx       <= '0;
      pad_left  <= '0;
      digits[0] <= '0;
    end else if (state == i2a_pkg::ST_DIV && div_rsp.done) begin
      digits[ndig[i2a_pkg::DIGIT_IDX_W-1:0]] <= div_rsp.rem[i2a_pkg::DIGIT_W-1:0];
      ndig <= ndig_inc;
      idx  <= ndig[i2a_pkg::DIGIT_IDX_W-1:0];
      if (div_finish) begin
        pad_left <= pad_needed ? (width - i2a_pkg::WIDTH_W'(ndig_inc)) : '0;
      end
    end else if (emit) begin
      if (state == i2a_pkg::ST_PAD) begin
        pad_left <= pad_left - i2a_pkg::WIDTH_W'(1);
      end
      if (state == i2a_pkg::ST_DIGIT && idx != '0) begin
        idx <= idx - i2a_pkg::DIGIT_IDX_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_out  <= emit_char;
      fg_out    <= fg;
      bg_out    <= bg;
      last_char <= emit_last;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== rtl/integer_to_ascii_padded_unit.sv =====
// top level of the padded integer to ascii converter
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   request  | push / full          | value, radix, min_width, pad_char, fg/bg_color
//   result   | pop / empty          | char_out, fg_out, bg_out, last_char
//
// a request emits 1 to 64 characters; sign first (radix ten only), then pads, then digits
// each digit of a nonzero value takes one pass through the divider (8 quotient bits a
// cycle over 32 bits), then characters leave at one per cycle while no held result stalls
// the back end; the queue holds two classified requests
// rst is synchronous and clears the queue, the sequencer and the result register
// a held result (pop low) stalls only the back end; the front keeps filling the queue

module integer_to_ascii_padded_unit (
  input  logic                         clk,
  input  logic                         rst,
  // request side
  input  logic                         push,
  output logic                         full,
  input  logic [i2a_pkg::VALUE_W-1:0]  value,
  input  logic [i2a_pkg::RADIX_W-1:0]  radix,
  input  logic [i2a_pkg::WIDTH_W-1:0]  min_width,
  input  logic [i2a_pkg::CHAR_W-1:0]   pad_char,
  input  logic [i2a_pkg::COLOR_W-1:0]  fg_color,
  input  logic [i2a_pkg::COLOR_W-1:0]  bg_color,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic [i2a_pkg::CHAR_W-1:0]   char_out,
  output logic [i2a_pkg::COLOR_W-1:0]  fg_out,
  output logic [i2a_pkg::COLOR_W-1:0]  bg_out,
  output logic                         last_char
);

  // front to queue
  logic              q_wr;
  i2a_pkg::desc_t    q_wdata;
  logic              q_full;

  // queue to back
  logic              q_pop;
  i2a_pkg::desc_t    q_rdata;
  logic              q_empty;

  // back to divider
  i2a_pkg::div_req_t div_req;
  i2a_pkg::div_rsp_t div_rsp;

  // classify sign, radix clamp, width clamp and zero
  i2a_front u_front (
    .push      (push),
    .value     (value),
    .radix     (radix),
    .min_width (min_width),
    .pad_char  (pad_char),
    .fg_color  (fg_color),
    .bg_color  (bg_color),
    .q_full    (q_full),
    .full      (full),
    .wr_en     (q_wr),
    .wr_data   (q_wdata)
  );

  // decouples request acceptance from the long conversion
  i2a_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  // one digit per division: remainder is the digit, quotient feeds the next pass
  i2a_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // digits are produced least significant first and replayed in reverse
  i2a_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .pop       (pop),
    .empty     (empty),
    .char_out  (char_out),
    .fg_out    (fg_out),
    .bg_out    (bg_out),
    .last_char (last_char)
  );

endmodule

// ===== rtl/i2a_checker.sv =====
// port level checks for the padded integer to ascii converter, bound to the top
module i2a_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [i2a_pkg::CHAR_W-1:0]   char_out,
  input logic [i2a_pkg::COLOR_W-1:0]  fg_out,
  input logic [i2a_pkg::COLOR_W-1:0]  bg_out,
  input logic                         last_char
);

  // reset leaves no result waiting and room for requests
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or full flag survived reset");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(char_out) && $stable(fg_out) &&
                       $stable(bg_out) && $stable(last_char))
    else $error("waiting result changed before pop");

  // a number always ends on a digit character
  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    !empty && last_char |->
      (char_out >= 8'h30 && char_out <= 8'h39) ||
      (char_out >= 8'h41 && char_out <= 8'h46))
    else $error("final character is not a digit");

  // inside one number characters stream without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !last_char |=> !empty)
    else $error("gap inside a number");

endmodule

bind integer_to_ascii_padded_unit i2a_checker u_i2a_checker (.*);

// ===== bench/integer_to_ascii_padded_unit_tb.sv =====
// self-checking testbench for the padded integer to ascii converter
module integer_to_ascii_padded_unit_tb;

  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_NUMBERS = 208;
  // once fewer numbers than this are left to send, neither side idles
  localparam int CALM_TAIL      = 30;
  localparam int GAP_MAX        = 18;
  // worst quiet stretch: 32 radix-2 digits through the divider, a full
  // 64 character burst queued behind it and both sides idling
  localparam int WATCHDOG_LIMIT = 4000;
  // after the last character, wait out one more slowest conversion
  localparam int SETTLE_CYCLES  = 400;
  localparam int SHOWN_FAULTS   = 10;

  localparam int unsigned RADIX_LO  = 2;
  localparam int unsigned RADIX_HI  = 16;
  localparam int unsigned RADIX_DEC = 10;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;

  // one conversion request; hold_for_drain makes the sender wait for an empty pipe
  typedef struct packed {
    logic [i2a_pkg::VALUE_W-1:0] value;
    logic [i2a_pkg::RADIX_W-1:0] radix;
    logic [i2a_pkg::WIDTH_W-1:0] min_width;
    logic [i2a_pkg::CHAR_W-1:0]  pad;
    logic [i2a_pkg::COLOR_W-1:0] fg;
    logic [i2a_pkg::COLOR_W-1:0] bg;
    logic                        hold_for_drain;
  } number_req_t;

  // one emitted character as seen on the result ports
  typedef struct packed {
    logic [i2a_pkg::CHAR_W-1:0]  ch;
    logic [i2a_pkg::COLOR_W-1:0] fg;
    logic [i2a_pkg::COLOR_W-1:0] bg;
    logic                        last;
  } glyph_t;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        push      = 1'b0;
  logic                        full;
  logic [i2a_pkg::VALUE_W-1:0] value     = '0;
  logic [i2a_pkg::RADIX_W-1:0] radix     = '0;
  logic [i2a_pkg::WIDTH_W-1:0] min_width = '0;
  logic [i2a_pkg::CHAR_W-1:0]  pad_char  = '0;
  logic [i2a_pkg::COLOR_W-1:0] fg_color  = '0;
  logic [i2a_pkg::COLOR_W-1:0] bg_color  = '0;
  logic                        empty;
  logic                        pop       = 1'b0;
  logic [i2a_pkg::CHAR_W-1:0]  char_out;
  logic [i2a_pkg::COLOR_W-1:0] fg_out;
  logic [i2a_pkg::COLOR_W-1:0] bg_out;
  logic                        last_char;

  number_req_t numbers_to_send[$];
  glyph_t      glyphs_due[$];

  int numbers_total = 0;
  int numbers_taken = 0;
  int fault_count   = 0;
  int quiet_cycles  = 0;
  int send_gap      = 0;
  int pop_gap       = 0;
  bit req_fire      = 1'b0;

  integer_to_ascii_padded_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .radix     (radix),
    .min_width (min_width),
    .pad_char  (pad_char),
    .fg_color  (fg_color),
    .bg_color  (bg_color),
    .empty     (empty),
    .pop       (pop),
    .char_out  (char_out),
    .fg_out    (fg_out),
    .bg_out    (bg_out),
    .last_char (last_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expands one request into the characters it must produce, in order
  function automatic void spell_number(number_req_t r);
    logic [7:0]  lsd [0:31];
    logic [31:0] mag;
    logic [3:0]  d;
    int unsigned base;
    int unsigned ndig;
    int unsigned nsign;
    int unsigned npad;
    int unsigned total;
    int unsigned pos;
    glyph_t      g;
    // out-of-range radix folds onto the nearest legal one
    base = 32'(r.radix);
    if (base < RADIX_LO) base = RADIX_LO;
    if (base > RADIX_HI) base = RADIX_HI;
    mag   = r.value;
    ndig  = 0;
    nsign = 0;
    npad  = 0;
    if (mag == 0) begin
      // zero is a lone digit: no sign, width ignored
      lsd[0] = CH_ZERO;
      ndig   = 1;
    end else begin
      // sign only in decimal; other radixes print the raw bit pattern
      if (base == RADIX_DEC && mag[31]) begin
        nsign = 1;
        mag   = -mag;
      end
      while (mag != 0) begin
        d         = 4'(mag % base);
        lsd[ndig] = 8'((d < 10) ? CH_ZERO + d : CH_A + (d - 10));
        ndig++;
        mag = mag / base;
      end
      // width counts digits only and the 6-bit field already caps it at 63
      if (r.min_width > ndig) npad = r.min_width - ndig;
    end
    total = nsign + npad + ndig;
    for (pos = 0; pos < total; pos++) begin
      if (pos < nsign) g.ch = CH_MINUS;
      else if (pos < nsign + npad) g.ch = r.pad;
      else g.ch = lsd[total - 1 - pos];
      g.fg   = r.fg;
      g.bg   = r.bg;
      g.last = (pos == total - 1);
      glyphs_due.push_back(g);
    end
  endfunction

  task automatic queue_number(input logic [31:0] v, input logic [4:0] rdx,
                              input logic [5:0] w, input logic [7:0] pd,
                              input logic [3:0] f, input logic [3:0] b,
                              input bit drain);
    number_req_t n;
    n.value          = v;
    n.radix          = rdx;
    n.min_width      = w;
    n.pad            = pd;
    n.fg             = f;
    n.bg             = b;
    n.hold_for_drain = drain;
    numbers_to_send.push_back(n);
  endtask

  // request driver: holds a request until it is taken, idles in random bursts
  always @(negedge clk) begin : send_side
    number_req_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else if (push && !req_fire) begin
      // request still blocked by full, keep it steady
    end else if (send_gap > 0) begin
      send_gap--;
      push <= 1'b0;
    end else if (numbers_to_send.size() == 0) begin
      push <= 1'b0;
    end else if (numbers_to_send[0].hold_for_drain && glyphs_due.size() != 0) begin
      // let every outstanding character come out before this request
      push <= 1'b0;
    end else if (numbers_to_send.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(1, GAP_MAX) - 1;
      push <= 1'b0;
    end else begin
      nxt = numbers_to_send.pop_front();
      value     <= nxt.value;
      radix     <= nxt.radix;
      min_width <= nxt.min_width;
      pad_char  <= nxt.pad;
      fg_color  <= nxt.fg;
      bg_color  <= nxt.bg;
      push      <= 1'b1;
    end
  end

  // result side: pop stalls in random bursts until the tail of the run
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (numbers_to_send.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
      pop_gap = $urandom_range(1, GAP_MAX) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // sample both handshakes at the rising edge: predict on requests, check on results
  always @(posedge clk) begin : track
    number_req_t taken;
    glyph_t      got;
    glyph_t      want;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= push && !full;
      if (push && !full) begin
        taken.value          = value;
        taken.radix          = radix;
        taken.min_width      = min_width;
        taken.pad            = pad_char;
        taken.fg             = fg_color;
        taken.bg             = bg_color;
        taken.hold_for_drain = 1'b0;
        spell_number(taken);
        numbers_taken++;
      end
      if (pop && !empty) begin
        got.ch   = char_out;
        got.fg   = fg_out;
        got.bg   = bg_out;
        got.last = last_char;
        if (glyphs_due.size() == 0) begin
          if (fault_count < SHOWN_FAULTS)
            $display("unexpected char: ch=%h fg=%h bg=%h last=%b",
                     got.ch, got.fg, got.bg, got.last);
          fault_count++;
        end else begin
          want = glyphs_due.pop_front();
          if (got.ch !== want.ch || got.fg !== want.fg ||
              got.bg !== want.bg || got.last !== want.last) begin
            if (fault_count < SHOWN_FAULTS)
              $display({"char mismatch: expected ch=%h fg=%h bg=%h last=%b, ",
                        "got ch=%h fg=%h bg=%h last=%b"},
                       want.ch, want.fg, want.bg, want.last,
                       got.ch, got.fg, got.bg, got.last);
            fault_count++;
          end
        end
      end
    end
  end

  // watchdog: too long without any request or character moving
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          i;
    int unsigned base;
    int unsigned k;
    logic [31:0] v;
    logic [31:0] p;
    logic [4:0]  rdx;
    logic [5:0]  w;

    // zero: single '0' whatever the width, radix or pad
    queue_number(32'h0000_0000, 5'd10, 6'd20, "*", 4'h3, 4'hC, 1'b0);
    queue_number(32'h0000_0000, 5'd0, 6'd63, 8'hFF, 4'hF, 4'hF, 1'b0);
    // most negative value: '-' then 2147483648 in decimal, raw pattern in hex
    queue_number(32'h8000_0000, 5'd10, 6'd0, "0", 4'h1, 4'h2, 1'b0);
    queue_number(32'h8000_0000, 5'd16, 6'd12, " ", 4'h0, 4'h0, 1'b0);
    queue_number(32'h7FFF_FFFF, 5'd10, 6'd63, ".", 4'hA, 4'h5, 1'b0);
    // all ones in binary: 32 digits, then with the width pinned at its top
    queue_number(32'hFFFF_FFFF, 5'd2, 6'd0, "x", 4'h5, 4'hA, 1'b0);
    queue_number(32'hFFFF_FFFF, 5'd2, 6'd63, 8'h00, 4'hF, 4'h0, 1'b0);
    // longest burst: sign, 62 pads and one digit; sent into an empty pipe
    queue_number(32'hFFFF_FFFF, 5'd10, 6'd63, "0", 4'h0, 4'hF, 1'b1);
    // radix below two behaves as binary
    queue_number(32'd5, 5'd0, 6'd8, "_", 4'h7, 4'h8, 1'b0);
    queue_number(32'd255, 5'd1, 6'd0, "_", 4'h8, 4'h7, 1'b0);
    // radix above sixteen behaves as hex
    queue_number(32'hDEAD_BEEF, 5'd17, 6'd0, " ", 4'h2, 4'h4, 1'b0);
    queue_number(32'hCAFE_F00D, 5'd31, 6'd9, "0", 4'h4, 4'h2, 1'b0);
    queue_number(32'h00AB_CDEF, 5'd16, 6'd8, "0", 4'hF, 4'h0, 1'b0);
    queue_number(32'd1, 5'd3, 6'd1, "#", 4'h6, 4'h9, 1'b0);
    // small negatives: decimal gets a sign, octal gets the raw pattern
    queue_number(-32'sd42, 5'd10, 6'd5, " ", 4'h9, 4'h6, 1'b0);
    queue_number(32'd7, 5'd10, 6'd0, 8'h00, 4'hB, 4'hD, 1'b0);
    queue_number(-32'sd8, 5'd8, 6'd0, " ", 4'hD, 4'hB, 1'b0);
    queue_number(32'd12345, 5'd7, 6'd2, "-", 4'hC, 4'h3, 1'b0);
    // width equal to, just below and above the digit count
    queue_number(32'd100, 5'd10, 6'd3, "#", 4'hE, 4'h1, 1'b0);
    queue_number(32'd1000, 5'd10, 6'd3, "#", 4'h1, 4'hE, 1'b0);
    queue_number(32'd15, 5'd16, 6'd2, "0", 4'h0, 4'hF, 1'b0);
    queue_number(32'd36, 5'd6, 6'd40, 8'h80, 4'h5, 4'h5, 1'b0);

    for (i = 0; i < RANDOM_NUMBERS; i++) begin
      // mostly legal radixes, some from the whole 5-bit field
      rdx  = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(2, 16));
      base = (rdx < RADIX_LO) ? RADIX_LO : (rdx > RADIX_HI) ? RADIX_HI : 32'(rdx);
      case ($urandom_range(0, 9))
        0: v = '0;
        1: v = 32'($urandom_range(0, 2000)) - 32'd1000;
        2: begin
          case ($urandom_range(0, 3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            default: v = 32'd1;
          endcase
        end
        3: begin
          // powers of the radix and one below: digit count boundaries
          p = 32'd1;
          k = $urandom_range(1, 8);
          repeat (k) p = p * base;
          v = p - 32'($urandom_range(0, 1));
        end
        default: v = $urandom();
      endcase
      // narrow widths mostly, the full range now and then
      w = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                      : 6'($urandom_range(0, 10));
      queue_number(v, rdx, w, 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   (i == 0) || ($urandom_range(0, 39) == 0));
    end
    numbers_total = numbers_to_send.size();

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // every request taken, every character out, then a quiet spell
    while (numbers_taken != numbers_total) @(negedge clk);
    while (glyphs_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fault_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
